// ===== hdl/rsa_pkg.sv =====
// ----------------------------------------------------------------------------
// rsa_pkg
// Shared types and defaults for the round-trip-time statistics block.
// ----------------------------------------------------------------------------
package rsa_pkg;

    localparam int RTT_BITS_DEF   = 24;
    localparam int COUNT_BITS_DEF = 16;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SQR,
        S_ACC,
        S_AVG_GO,
        S_AVG_W,
        S_D2_MUL,
        S_D2_GO,
        S_D2_W,
        S_D3_GO,
        S_D3_W,
        S_Q_GO,
        S_Q_W,
        S_M_MUL,
        S_SUB,
        S_RT_GO,
        S_RT_W,
        S_DONE
    } t_state;

    typedef enum logic {
        UOP_DIV,
        UOP_SQRT
    } t_unit_op;

    typedef struct packed {
        logic     start;
        t_unit_op op;
    } t_unit_req;

endpackage

// ===== hdl/rtt_statistics_accumulator_top.sv =====
// ----------------------------------------------------------------------------
// rtt_statistics_accumulator_top
// Running min/max/mean/mdev/EWMA statistics over round-trip-time samples.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall) carries i_operation and i_rtt_us.
//   Operation 0 folds a sample in (square, then update), no result. Once the
//   count saturates, samples are dropped.
//   Operation 1 reports and clears: one result on the output channel
//   (o_valid / i_stall). With samples present, the mean, two divides for the
//   variance (one divide, then a square and a subtract, once the sum reaches
//   INT_MAX) and one square root run in turn on the shared bit-serial
//   divide/square-root unit.
//   An empty report sets o_no_samples; it loads its result and frees the
//   input in the same cycle, once the output register is free.
//   o_stall is high whenever the sequencer is busy. A finished result sits
//   in the output register; samples may still be taken while it waits, but
//   a following report holds at its end until the receiver takes the first.
//   Reset (synchronous, active low) clears all statistics and both valids.
// ----------------------------------------------------------------------------
module rtt_statistics_accumulator_top #(
    parameter int RTT_BITS   = rsa_pkg::RTT_BITS_DEF,
    parameter int COUNT_BITS = rsa_pkg::COUNT_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_operation,
    input  logic [23:0] i_rtt_us,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [23:0] o_min_rtt_us,
    output logic [23:0] o_max_rtt_us,
    output logic [23:0] o_avg_rtt_us,
    output logic [23:0] o_mdev_rtt_us,
    output logic [26:0] o_ewma_rtt_x8,
    output logic [15:0] o_sample_total,
    output logic        o_no_samples
);

    localparam int SUM_W = RTT_BITS + COUNT_BITS;
    localparam int SQ_W  = 2 * RTT_BITS + COUNT_BITS;
    localparam int MW    = (SUM_W < 31) ? SUM_W : 31;
    localparam int PW    = 2 * MW;
    localparam int DW0   = (PW > SQ_W) ? PW : SQ_W;
    localparam int UW    = DW0 + (DW0 % 2);
    localparam int EW    = RTT_BITS + 3;
    localparam logic [63:0] INT_MAX = 64'd2147483647;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    rsa_pkg::t_state r_state;
    rsa_pkg::t_state n_state;

    logic [RTT_BITS-1:0]   r_rtt;
    logic [RTT_BITS-1:0]   r_min;
    logic [RTT_BITS-1:0]   r_max;
    logic                  r_ext_valid;
    logic [SUM_W-1:0]      r_sum;
    logic [SQ_W-1:0]       r_sumsq;
    logic [COUNT_BITS-1:0] r_count;
    logic [EW-1:0]         r_ewma;
    logic [PW-1:0]         r_prod;
    logic [UW-1:0]         r_t;
    logic [RTT_BITS-1:0]   r_mean;
    logic [23:0]           r_mdev;
    logic                  r_empty;

    logic        r_out_valid;
    logic [23:0] r_o_min;
    logic [23:0] r_o_max;
    logic [23:0] r_o_avg;
    logic [23:0] r_o_mdev;
    logic [26:0] r_o_ewma;
    logic [15:0] r_o_count;
    logic        r_o_empty;

    rsa_pkg::t_unit_req w_req;
    logic [UW-1:0]      w_arg;
    logic               w_done;
    logic [UW-1:0]      w_result;
    logic [MW-1:0]      w_mul_a;
    logic [PW-1:0]      w_prod;
    logic [EW:0]        w_ewma_next;
    logic               w_in_xfer;
    logic               w_load;
    logic               w_small_sum;

    rsa_unit #(
        .UW  (UW),
        .DVW (COUNT_BITS)
    ) u_unit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (w_req),
        .i_arg    (w_arg),
        .i_div    (r_count),
        .o_done   (w_done),
        .o_result (w_result)
    );

    assign w_in_xfer   = i_valid && !o_stall;
    assign w_load      = (r_state == rsa_pkg::S_DONE) && (!r_out_valid || !i_stall);
    assign w_small_sum = (64'(r_sum) < INT_MAX);
    assign w_prod      = PW'(w_mul_a) * PW'(w_mul_a);
    assign w_ewma_next = {1'b0, r_ewma} + (EW+1)'(r_rtt) - (EW+1)'(r_ewma >> 3);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rsa_pkg::S_IDLE: begin
                if (w_in_xfer) begin
                    if (!i_operation) begin
                        if (r_count != COUNT_MAX) n_state = rsa_pkg::S_SQR;
                    end else if (r_count == '0) begin
                        n_state = rsa_pkg::S_DONE;
                    end else begin
                        n_state = rsa_pkg::S_AVG_GO;
                    end
                end
            end
            rsa_pkg::S_SQR:    n_state = rsa_pkg::S_ACC;
            rsa_pkg::S_ACC:    n_state = rsa_pkg::S_IDLE;
            rsa_pkg::S_AVG_GO: n_state = rsa_pkg::S_AVG_W;
            rsa_pkg::S_AVG_W: begin
                if (w_done) n_state = w_small_sum ? rsa_pkg::S_D2_MUL : rsa_pkg::S_Q_GO;
            end
            rsa_pkg::S_D2_MUL: n_state = rsa_pkg::S_D2_GO;
            rsa_pkg::S_D2_GO:  n_state = rsa_pkg::S_D2_W;
            rsa_pkg::S_D2_W:   if (w_done) n_state = rsa_pkg::S_D3_GO;
            rsa_pkg::S_D3_GO:  n_state = rsa_pkg::S_D3_W;
            rsa_pkg::S_D3_W:   if (w_done) n_state = rsa_pkg::S_RT_GO;
            rsa_pkg::S_Q_GO:   n_state = rsa_pkg::S_Q_W;
            rsa_pkg::S_Q_W:    if (w_done) n_state = rsa_pkg::S_M_MUL;
            rsa_pkg::S_M_MUL:  n_state = rsa_pkg::S_SUB;
            rsa_pkg::S_SUB:    n_state = rsa_pkg::S_RT_GO;
            rsa_pkg::S_RT_GO:  n_state = rsa_pkg::S_RT_W;
            rsa_pkg::S_RT_W:   if (w_done) n_state = rsa_pkg::S_DONE;
            rsa_pkg::S_DONE:   if (w_load) n_state = rsa_pkg::S_IDLE;
            default:           n_state = rsa_pkg::S_IDLE;
        endcase
    end

    // sequencer outputs: unit launch, operand and multiplier selects
    always_comb begin
        w_req.start = 1'b0;
        w_req.op    = rsa_pkg::UOP_DIV;
        w_arg       = '0;
        w_mul_a     = MW'(r_rtt);
        o_stall     = (r_state != rsa_pkg::S_IDLE);
        case (r_state)
            rsa_pkg::S_AVG_GO: begin
                w_req.start = 1'b1;
                w_arg       = UW'(r_sum);
            end
            rsa_pkg::S_D2_GO: begin
                w_req.start = 1'b1;
                w_arg       = UW'(r_prod);
            end
            rsa_pkg::S_D3_GO: begin
                w_req.start = 1'b1;
                w_arg       = r_t;
            end
            rsa_pkg::S_Q_GO: begin
                w_req.start = 1'b1;
                w_arg       = UW'(r_sumsq);
            end
            rsa_pkg::S_RT_GO: begin
                w_req.start = 1'b1;
                w_req.op    = rsa_pkg::UOP_SQRT;
                w_arg       = r_t;
            end
            rsa_pkg::S_D2_MUL: w_mul_a = r_sum[MW-1:0];
            rsa_pkg::S_M_MUL:  w_mul_a = MW'(r_mean);
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rsa_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_ext_valid <= 1'b0;
            r_min       <= '0;
            r_max       <= '0;
            r_sum       <= '0;
            r_sumsq     <= '0;
            r_count     <= '0;
            r_ewma      <= '0;
            r_empty     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) r_out_valid <= 1'b1;
            else if (r_out_valid && !i_stall) r_out_valid <= 1'b0;
            case (r_state)
                rsa_pkg::S_IDLE: begin
                    if (w_in_xfer) begin
                        r_rtt   <= i_rtt_us[RTT_BITS-1:0];
                        r_empty <= (r_count == '0);
                    end
                end
                rsa_pkg::S_SQR: r_prod <= w_prod;
                rsa_pkg::S_ACC: begin
                    if (!r_ext_valid || r_rtt < r_min) r_min <= r_rtt;
                    if (!r_ext_valid || r_rtt > r_max) r_max <= r_rtt;
                    r_ext_valid <= 1'b1;
                    r_sum       <= r_sum + SUM_W'(r_rtt);
                    r_sumsq     <= r_sumsq + SQ_W'(r_prod);
                    r_count     <= r_count + 1'b1;
                    if (r_ewma == '0) r_ewma <= EW'({r_rtt, 3'b000});
                    else              r_ewma <= w_ewma_next[EW-1:0];
                end
                rsa_pkg::S_AVG_W:  if (w_done) r_mean <= w_result[RTT_BITS-1:0];
                rsa_pkg::S_D2_MUL: r_prod <= w_prod;
                rsa_pkg::S_D2_W:   if (w_done) r_t <= UW'(r_sumsq) - w_result;
                rsa_pkg::S_D3_W:   if (w_done) r_t <= w_result;
                rsa_pkg::S_Q_W:    if (w_done) r_t <= w_result;
                rsa_pkg::S_M_MUL:  r_prod <= w_prod;
                rsa_pkg::S_SUB:    r_t <= r_t - UW'(r_prod);
                rsa_pkg::S_RT_W:   if (w_done) r_mdev <= 24'(w_result);
                rsa_pkg::S_DONE: begin
                    if (w_load) begin
                        r_o_empty   <= r_empty;
                        if (r_empty) begin
                            r_o_min   <= '0;
                            r_o_max   <= '0;
                            r_o_avg   <= '0;
                            r_o_mdev  <= '0;
                            r_o_ewma  <= '0;
                            r_o_count <= '0;
                        end else begin
                            r_o_min   <= 24'(r_min);
                            r_o_max   <= 24'(r_max);
                            r_o_avg   <= 24'(r_mean);
                            r_o_mdev  <= r_mdev;
                            r_o_ewma  <= 27'(r_ewma);
                            r_o_count <= 16'(r_count);
                        end
                        // clear statistics for the next window
                        r_ext_valid <= 1'b0;
                        r_min       <= '0;
                        r_max       <= '0;
                        r_sum       <= '0;
                        r_sumsq     <= '0;
                        r_count     <= '0;
                        r_ewma      <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_valid        = r_out_valid;
    assign o_min_rtt_us   = r_o_min;
    assign o_max_rtt_us   = r_o_max;
    assign o_avg_rtt_us   = r_o_avg;
    assign o_mdev_rtt_us  = r_o_mdev;
    assign o_ewma_rtt_x8  = r_o_ewma;
    assign o_sample_total = r_o_count;
    assign o_no_samples   = r_o_empty;

`ifndef SYNTHESIS
    a_unit_quiet_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rsa_pkg::S_IDLE) |-> !w_done)
        else $error("arith unit finished while sequencer idle");

    a_extremes_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ext_valid |-> (r_min <= r_max))
        else $error("minimum above maximum");

    a_empty_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_no_samples) |-> (o_sample_total == '0 && o_ewma_rtt_x8 == '0))
        else $error("empty report carries data");

    a_count_after_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rsa_pkg::S_ACC) |=> (r_count != '0 && r_ext_valid))
        else $error("sample update lost");
`endif

endmodule

// ===== hdl/rsa_unit.sv =====
// ----------------------------------------------------------------------------
// rsa_unit
// Shared bit-serial unit: restoring divide (one quotient bit per cycle) or
// floor square root (one root bit per cycle) on one subtract/compare.
// ----------------------------------------------------------------------------
module rsa_unit #(
    parameter int UW  = 64,
    parameter int DVW = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rsa_pkg::t_unit_req i_req,
    input  logic [UW-1:0]      i_arg,
    input  logic [DVW-1:0]     i_div,
    output logic               o_done,
    output logic [UW-1:0]      o_result
);

    localparam int HW = UW / 2;
    localparam int RW = HW + 2;
    localparam int CW = $clog2(UW + 1);

    logic              r_busy;
    logic              r_done;
    rsa_pkg::t_unit_op r_op;
    logic [CW-1:0]     r_cnt;
    logic [UW-1:0]     r_val;
    logic [RW-1:0]     r_rem;
    logic [HW-1:0]     r_root;
    logic [DVW-1:0]    r_div;

    logic [RW-1:0] w_shift;
    logic [RW-1:0] w_trial;
    logic [RW-1:0] w_diff;
    logic          w_ge;

    always_comb begin
        if (r_op == rsa_pkg::UOP_SQRT) begin
            w_shift = {r_rem[RW-3:0], r_val[UW-1:UW-2]};
            w_trial = {r_root, 2'b01};
        end else begin
            w_shift = {r_rem[RW-2:0], r_val[UW-1]};
            w_trial = RW'(r_div);
        end
        w_ge   = (w_shift >= w_trial);
        w_diff = w_shift - w_trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_op   <= rsa_pkg::UOP_DIV;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_op   <= i_req.op;
                r_val  <= i_arg;
                r_rem  <= '0;
                r_root <= '0;
                r_div  <= i_div;
                r_cnt  <= (i_req.op == rsa_pkg::UOP_SQRT) ? CW'(HW) : CW'(UW);
            end else if (r_busy) begin
                r_rem <= w_ge ? w_diff : w_shift;
                if (r_op == rsa_pkg::UOP_SQRT) begin
                    r_val  <= {r_val[UW-3:0], 2'b00};
                    r_root <= {r_root[HW-2:0], w_ge};
                end else begin
                    r_val <= {r_val[UW-2:0], w_ge};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = (r_op == rsa_pkg::UOP_SQRT) ? UW'(r_root) : r_val;

endmodule
